/* rtl/core/spr_pkg.sv */
`timescale 1ns / 1ps

package spr_pkg;

    // operation codes of an input item
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_MOVE = 2'd1;
    localparam logic [1:0] OP_HOME = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_INITIAL_PERIOD     = 3'd0;
    localparam logic [2:0] REG_STEPS_PER_POSITION = 3'd1;
    localparam logic [2:0] REG_FAST_RAMP_DELTA    = 3'd2;
    localparam logic [2:0] REG_SLOW_RAMP_DELTA    = 3'd3;
    localparam logic [2:0] REG_FAST_RAMP_STEPS    = 3'd4;
    localparam logic [2:0] REG_SLOW_RAMP_STEPS    = 3'd5;

    // register reset values
    localparam logic [15:0] INITIAL_PERIOD_RST     = 16'd2500;
    localparam logic [6:0]  STEPS_PER_POSITION_RST = 7'd50;
    localparam logic [11:0] FAST_RAMP_DELTA_RST    = 12'd250;
    localparam logic [11:0] SLOW_RAMP_DELTA_RST    = 12'd125;
    localparam logic [7:0]  FAST_RAMP_STEPS_RST    = 8'd3;
    localparam logic [7:0]  SLOW_RAMP_STEPS_RST    = 8'd9;

    // ramp settings handed to the period update
    typedef struct packed {
        logic [11:0] fast_delta;
        logic [11:0] slow_delta;
        logic [7:0]  fast_steps;
        logic [7:0]  slow_steps;
    } spr_ramp_cfg_t;

    // coil drive pattern for each phase
    function automatic logic [5:0] coil_lut(input logic [1:0] phase);
        logic [5:0] pat;
        case (phase)
            2'd0:    pat = 6'h36;
            2'd1:    pat = 6'h2e;
            2'd2:    pat = 6'h2d;
            default: pat = 6'h35;
        endcase
        return pat;
    endfunction

endpackage

/* rtl/core/spr_ramp.sv */
`timescale 1ns / 1ps

module spr_ramp
    import spr_pkg::*;
(
    input  logic [15:0]   period,
    input  logic [7:0]    steps_total,
    input  logic [7:0]    steps_left,
    input  spr_ramp_cfg_t cfg,
    output logic [15:0]   period_next
);

    logic [7:0]         steps_done;
    logic [11:0]        sub_val;
    logic [11:0]        add_val;
    logic signed [18:0] p_sum;

    // accelerate near the start, decelerate near the end
    always_comb
    begin
        steps_done = steps_total - steps_left;
        sub_val    = '0;
        add_val    = '0;
        if (steps_done <= cfg.fast_steps)
        begin
            sub_val = cfg.fast_delta;
        end
        else if (steps_done <= cfg.slow_steps)
        begin
            sub_val = cfg.slow_delta;
        end
        if (steps_left <= cfg.fast_steps)
        begin
            add_val = cfg.fast_delta;
        end
        else if (steps_left <= cfg.slow_steps)
        begin
            add_val = cfg.slow_delta;
        end
        p_sum = signed'({3'b000, period}) - signed'({7'd0, sub_val})
              + signed'({7'd0, add_val});
    end

    // clamp to 1..65535
    always_comb
    begin
        if (p_sum < 19'sd1)
        begin
            period_next = 16'd1;
        end
        else if (p_sum > 19'sd65535)
        begin
            period_next = 16'hffff;
        end
        else
        begin
            period_next = p_sum[15:0];
        end
    end

endmodule

/* rtl/core/stepper_position_ramp_controller.sv */
`timescale 1ns / 1ps

// output: an accepted item's result is registered in the result buffer and shown once earlier results are taken
// throughput: one item per cycle; a two-entry result buffer keeps input ready
//   for one more item while the output is stalled
// reset: asynchronous, active low; motor state cleared, step period and
//   configuration registers return to their default values
module stepper_position_ramp_controller
    import spr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [1:0]  target_position,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  coil_pattern,
    output logic        step_taken,
    output logic        moving,
    output logic        homed,
    output logic [1:0]  current_position,
    output logic [7:0]  step_count,
    output logic [15:0] step_period
);

    typedef struct packed {
        logic [5:0]  coil_pattern;
        logic        step_taken;
        logic        moving;
        logic        homed;
        logic [1:0]  current_position;
        logic [7:0]  step_count;
        logic [15:0] step_period;
    } result_t;

    // configuration registers
    logic [15:0]   initial_period_reg;
    logic [6:0]    steps_per_position_reg;
    spr_ramp_cfg_t ramp_cfg_reg;

    // motor state
    logic [1:0]  coil_phase_reg,   coil_phase_next;
    logic        busy_reg,         busy_next;
    logic        dir_up_reg,       dir_up_next;
    logic [7:0]  steps_left_reg,   steps_left_next;
    logic [7:0]  steps_total_reg,  steps_total_next;
    logic [15:0] period_reg,       period_next;
    logic [15:0] tick_reg,         tick_next;
    logic [1:0]  position_reg,     position_next;
    logic [7:0]  home_steps_reg,   home_steps_next;
    logic        home_seen_reg,    home_seen_next;
    logic        stepped;

    // result buffer
    result_t     buf_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    result_t     res;
    result_t     head;

    logic        in_fire;
    logic        out_fire;
    logic [15:0] tick_inc;
    logic [15:0] ramp_period;
    logic [1:0]  pos_delta;
    logic [7:0]  move_steps;

    assign in_ready = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign in_fire = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_period_reg      <= INITIAL_PERIOD_RST;
            steps_per_position_reg  <= STEPS_PER_POSITION_RST;
            ramp_cfg_reg.fast_delta <= FAST_RAMP_DELTA_RST;
            ramp_cfg_reg.slow_delta <= SLOW_RAMP_DELTA_RST;
            ramp_cfg_reg.fast_steps <= FAST_RAMP_STEPS_RST;
            ramp_cfg_reg.slow_steps <= SLOW_RAMP_STEPS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_INITIAL_PERIOD:     initial_period_reg      <= cfg_data;
                REG_STEPS_PER_POSITION: steps_per_position_reg  <= cfg_data[6:0];
                REG_FAST_RAMP_DELTA:    ramp_cfg_reg.fast_delta <= cfg_data[11:0];
                REG_SLOW_RAMP_DELTA:    ramp_cfg_reg.slow_delta <= cfg_data[11:0];
                REG_FAST_RAMP_STEPS:    ramp_cfg_reg.fast_steps <= cfg_data[7:0];
                REG_SLOW_RAMP_STEPS:    ramp_cfg_reg.slow_steps <= cfg_data[7:0];
                default:                ;
            endcase
        end
    end

    // period update for the step being taken
    spr_ramp u_ramp (
        .period      (period_reg),
        .steps_total (steps_total_reg),
        .steps_left  (steps_left_reg),
        .cfg         (ramp_cfg_reg),
        .period_next (ramp_period)
    );

    // move distance: one or two positions, shortest way round
    always_comb
    begin
        pos_delta = target_position - position_reg;
        if (pos_delta == 2'd2)
        begin
            move_steps = {steps_per_position_reg, 1'b0};
        end
        else
        begin
            move_steps = {1'b0, steps_per_position_reg};
        end
    end

    assign tick_inc = tick_reg + 16'd1;

    // next state for the accepted item
    always_comb
    begin
        coil_phase_next  = coil_phase_reg;
        busy_next        = busy_reg;
        dir_up_next      = dir_up_reg;
        steps_left_next  = steps_left_reg;
        steps_total_next = steps_total_reg;
        period_next      = period_reg;
        tick_next        = tick_reg;
        position_next    = position_reg;
        home_steps_next  = home_steps_reg;
        home_seen_next   = home_seen_reg;
        stepped          = 1'b0;
        case (operation)
            OP_TICK:
            begin
                if (busy_reg)
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= period_reg)
                    begin
                        tick_next       = '0;
                        stepped         = 1'b1;
                        coil_phase_next = dir_up_reg ? coil_phase_reg + 2'd1
                                                     : coil_phase_reg - 2'd1;
                        home_steps_next = dir_up_reg ? home_steps_reg + 8'd1
                                                     : home_steps_reg - 8'd1;
                        period_next     = ramp_period;
                        steps_left_next = steps_left_reg - 8'd1;
                        if (steps_left_reg == 8'd1)
                        begin
                            busy_next = 1'b0;
                        end
                    end
                end
            end
            OP_MOVE:
            begin
                if (!busy_reg && pos_delta != 2'd0)
                begin
                    position_next    = target_position;
                    // one position up (mod 4) counts down, one down counts up; a half-turn to a lower index counts up
                    dir_up_next      = (pos_delta == 2'd2) ? (position_reg > target_position)
                                                           : (pos_delta == 2'd3);
                    steps_left_next  = move_steps;
                    steps_total_next = move_steps;
                    period_next      = (initial_period_reg == 16'd0) ? 16'd1
                                                                     : initial_period_reg;
                    tick_next        = '0;
                    busy_next        = (move_steps != 8'd0);
                end
            end
            OP_HOME:
            begin
                home_steps_next = '0;
                home_seen_next  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coil_phase_reg  <= '0;
            busy_reg        <= 1'b0;
            dir_up_reg      <= 1'b0;
            steps_left_reg  <= '0;
            steps_total_reg <= '0;
            period_reg      <= INITIAL_PERIOD_RST;
            tick_reg        <= '0;
            position_reg    <= '0;
            home_steps_reg  <= '0;
            home_seen_reg   <= 1'b0;
        end
        else if (in_fire)
        begin
            coil_phase_reg  <= coil_phase_next;
            busy_reg        <= busy_next;
            dir_up_reg      <= dir_up_next;
            steps_left_reg  <= steps_left_next;
            steps_total_reg <= steps_total_next;
            period_reg      <= period_next;
            tick_reg        <= tick_next;
            position_reg    <= position_next;
            home_steps_reg  <= home_steps_next;
            home_seen_reg   <= home_seen_next;
        end
    end

    // result of the accepted item
    always_comb
    begin
        res.coil_pattern     = coil_lut(coil_phase_next);
        res.step_taken       = stepped;
        res.moving           = busy_next;
        res.homed            = home_seen_next;
        res.current_position = position_next;
        res.step_count       = home_steps_next;
        res.step_period      = period_next;
    end

    // result buffer pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (out_fire)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (in_fire && !out_fire)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (!in_fire && out_fire)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // result buffer storage
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            buf_reg[wr_ptr_reg] <= res;
        end
    end

    assign head             = buf_reg[rd_ptr_reg];
    assign coil_pattern     = head.coil_pattern;
    assign step_taken       = head.step_taken;
    assign moving           = head.moving;
    assign homed            = head.homed;
    assign current_position = head.current_position;
    assign step_count       = head.step_count;
    assign step_period      = head.step_period;

    // checks
    a_busy_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> steps_left_reg != 8'd0)
        else $error("busy with no steps left");

    a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        period_reg != 16'd0)
        else $error("step period is zero");

    a_phase_only_on_item: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(coil_phase_reg) && $stable(home_steps_reg))
        else $error("motor state changed without an item");

    a_buffer_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !out_fire |=> out_valid)
        else $error("accepted item produced no result");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer overflow");

endmodule
